### design/lcp_pkg.sv
// ----------------------------------------------------------------------------
// lcp_pkg
// Shared widths, constants and types of the coefficient compress/pack block.
// ----------------------------------------------------------------------------
package lcp_pkg;

    localparam int COEFF_W = 12;
    localparam int BYTE_W  = 8;
    localparam int CFG_W   = 4;
    localparam int CMP_W   = 11;
    localparam int NUM_W   = 23;
    localparam int RECIP_W = 24;
    localparam int PROD_W  = NUM_W + RECIP_W;
    localparam int QUO_W   = 12;
    localparam int ACC_W   = 7;
    localparam int CNT_W   = 3;
    localparam int SUM_W   = 5;
    localparam int WIDE_W  = 18;

    localparam logic [CFG_W-1:0]   CFG_D11     = 4'd11;
    localparam logic [CFG_W-1:0]   CFG_RESET   = 4'd10;
    localparam logic [NUM_W-1:0]   HALF_Q      = 23'd1664;
    localparam logic [RECIP_W-1:0] RECIP_Q     = 24'd10321340;
    localparam int                 RECIP_SHIFT = 35;
    localparam logic [SUM_W-1:0]   D_NARROW    = 5'd10;
    localparam logic [SUM_W-1:0]   D_WIDE      = 5'd11;
    localparam logic [SUM_W-1:0]   ONE_BYTE    = 5'd8;
    localparam logic [SUM_W-1:0]   TWO_BYTES   = 5'd16;

    typedef struct packed {
        logic [CMP_W-1:0] value;
        logic             vector_end;
    } comp_item_t;

    typedef struct packed {
        logic [BYTE_W-1:0] byte0;
        logic [BYTE_W-1:0] byte1;
        logic              two;
    } byte_pair_t;

endpackage

### design/lcp_if.sv
// ----------------------------------------------------------------------------
// lcp_if
// Valid/ready channels: coefficient input and packed byte output.
// ----------------------------------------------------------------------------
interface lcp_coeff_if;
    import lcp_pkg::*;

    logic               valid;
    logic               ready;
    logic [COEFF_W-1:0] coeff_value;
    logic               vector_end;

    modport source (output valid, output coeff_value, output vector_end, input ready);
    modport sink   (input valid, input coeff_value, input vector_end, output ready);
endinterface

interface lcp_byte_if;
    import lcp_pkg::*;

    logic              valid;
    logic              ready;
    logic [BYTE_W-1:0] packed_byte;
    logic              run_last;

    modport source (output valid, output packed_byte, output run_last, input ready);
    modport sink   (input valid, input packed_byte, input run_last, output ready);
endinterface

### design/lcp_compress.sv
// ----------------------------------------------------------------------------
// lcp_compress
// Input register and round(x * 2^d / q) mod 2^d by reciprocal multiply.
// ----------------------------------------------------------------------------
module lcp_compress (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                d11,
    lcp_coeff_if.sink           coeff,
    output logic                item_valid,
    output lcp_pkg::comp_item_t item,
    input  logic                item_ready
);
    import lcp_pkg::*;

    logic               in_valid_reg;
    logic [COEFF_W-1:0] x_reg;
    logic               end_reg;
    logic               comp_valid_reg;
    comp_item_t         comp_reg;
    comp_item_t         comp_next;
    logic               comp_ready;
    logic               comp_load;
    logic [NUM_W-1:0]   num;
    logic [PROD_W-1:0]  prod;
    logic [QUO_W-1:0]   quo;

    assign comp_ready  = !comp_valid_reg || item_ready;
    assign comp_load   = in_valid_reg && comp_ready;
    assign coeff.ready = !in_valid_reg || comp_ready;
    assign item_valid  = comp_valid_reg;
    assign item        = comp_reg;

    always_comb
    begin
        if (d11)
        begin
            num = (NUM_W'(x_reg) << 11) + HALF_Q;
        end
        else
        begin
            num = (NUM_W'(x_reg) << 10) + HALF_Q;
        end
        prod = PROD_W'(num) * PROD_W'(RECIP_Q);
        quo  = prod[RECIP_SHIFT +: QUO_W];
        comp_next.vector_end = end_reg;
        if (d11)
        begin
            comp_next.value = quo[CMP_W-1:0];
        end
        else
        begin
            comp_next.value = {1'b0, quo[CMP_W-2:0]};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg   <= 1'b0;
            comp_valid_reg <= 1'b0;
        end
        else
        begin
            if (coeff.ready)
            begin
                in_valid_reg <= coeff.valid;
            end
            if (comp_ready)
            begin
                comp_valid_reg <= in_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (coeff.valid && coeff.ready)
        begin
            x_reg   <= coeff.coeff_value;
            end_reg <= coeff.vector_end;
        end
        if (comp_load)
        begin
            comp_reg <= comp_next;
        end
    end

endmodule

### design/lcp_packer.sv
// ----------------------------------------------------------------------------
// lcp_packer
// Bit accumulator, byte split and one-byte-per-cycle output sequencing, held while the sink is not ready.
// ----------------------------------------------------------------------------
module lcp_packer (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                d11,
    input  logic                clear,
    input  logic                item_valid,
    input  lcp_pkg::comp_item_t item,
    output logic                item_ready,
    lcp_byte_if.source          byte_stream
);
    import lcp_pkg::*;

    logic [ACC_W-1:0]  acc_reg;
    logic [ACC_W-1:0]  acc_next;
    logic [CNT_W-1:0]  cnt_reg;
    logic [CNT_W-1:0]  cnt_next;
    logic              pair_valid_reg;
    byte_pair_t        pair_reg;
    byte_pair_t        pair_next;
    logic              sel_reg;
    logic [WIDE_W-1:0] wide;
    logic [SUM_W-1:0]  cnt_sum;
    logic [SUM_W-1:0]  cnt_rem;
    logic              pair_free;
    logic              take;
    logic              out_fire;

    assign byte_stream.valid       = pair_valid_reg;
    assign byte_stream.packed_byte = sel_reg ? pair_reg.byte1 : pair_reg.byte0;
    assign byte_stream.run_last    = !pair_reg.two || sel_reg;
    assign out_fire                = byte_stream.valid && byte_stream.ready;
    assign pair_free               = !pair_valid_reg || (out_fire && byte_stream.run_last);
    assign item_ready              = pair_free;
    assign take                    = item_valid && pair_free;

    always_comb
    begin
        wide    = (WIDE_W'(item.value) << cnt_reg) | WIDE_W'(acc_reg);
        cnt_sum = SUM_W'(cnt_reg) + (d11 ? D_WIDE : D_NARROW);
        pair_next.byte0 = wide[7:0];
        pair_next.byte1 = wide[15:8];
        if (cnt_sum >= TWO_BYTES)
        begin
            cnt_rem        = cnt_sum - TWO_BYTES;
            pair_next.two  = 1'b1;
            acc_next       = ACC_W'(wide[WIDE_W-1:16]);
        end
        else
        begin
            cnt_rem        = cnt_sum - ONE_BYTE;
            pair_next.two  = item.vector_end && (cnt_rem != '0);
            acc_next       = wide[14:8];
        end
        cnt_next = cnt_rem[CNT_W-1:0];
        if (item.vector_end)
        begin
            acc_next = '0;
            cnt_next = '0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            acc_reg        <= '0;
            cnt_reg        <= '0;
            pair_valid_reg <= 1'b0;
            sel_reg        <= 1'b0;
        end
        else
        begin
            if (clear)
            begin
                acc_reg <= '0;
                cnt_reg <= '0;
            end
            else if (take)
            begin
                acc_reg <= acc_next;
                cnt_reg <= cnt_next;
            end
            if (take)
            begin
                pair_valid_reg <= 1'b1;
                sel_reg        <= 1'b0;
            end
            else if (out_fire)
            begin
                if (byte_stream.run_last)
                begin
                    pair_valid_reg <= 1'b0;
                    sel_reg        <= 1'b0;
                end
                else
                begin
                    sel_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (take)
        begin
            pair_reg <= pair_next;
        end
    end

endmodule

### design/lattice_coeff_compress_pack_unit.sv
// ----------------------------------------------------------------------------
// lattice_coeff_compress_pack_unit
// Compress coefficients to 10 or 11 bits and pack them into a byte stream.
// ----------------------------------------------------------------------------
// Path: input register, compress register and byte-pair register, which offers
//   the first byte. Throughput: 1 coefficient per cycle when it yields one byte
//   and the output is not stalled; a two-byte one holds the next until both leave.
// Reset: asynchronous, clears the accumulator, all valid flags and sets d = 10.
// A configuration write clears the accumulator.
// ----------------------------------------------------------------------------
module lattice_coeff_compress_pack_unit (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      cfg_wr_en,
    input  logic [lcp_pkg::CFG_W-1:0] cfg_wr_data,
    lcp_coeff_if.sink                 coeff,
    lcp_byte_if.source                byte_stream
);
    import lcp_pkg::*;

    logic [CFG_W-1:0] bits_per_coeff_reg;
    logic             d11;
    logic             item_valid;
    logic             item_ready;
    comp_item_t       item;

    assign d11 = (bits_per_coeff_reg == CFG_D11);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bits_per_coeff_reg <= CFG_RESET;
        end
        else if (cfg_wr_en)
        begin
            bits_per_coeff_reg <= cfg_wr_data;
        end
    end

    lcp_compress u_compress (
        .clk        (clk),
        .rst_n      (rst_n),
        .d11        (d11),
        .coeff      (coeff),
        .item_valid (item_valid),
        .item       (item),
        .item_ready (item_ready)
    );

    lcp_packer u_packer (
        .clk         (clk),
        .rst_n       (rst_n),
        .d11         (d11),
        .clear       (cfg_wr_en),
        .item_valid  (item_valid),
        .item        (item),
        .item_ready  (item_ready),
        .byte_stream (byte_stream)
    );

endmodule

### design/lcp_checker.sv
// ----------------------------------------------------------------------------
// lcp_checker
// Port-level checks on the compress/pack unit, bound to the top level.
// ----------------------------------------------------------------------------
module lcp_checker (
    input logic                       clk,
    input logic                       rst_n,
    input logic                       in_ready,
    input logic                       out_valid,
    input logic                       out_ready,
    input logic [lcp_pkg::BYTE_W-1:0] packed_byte,
    input logic                       run_last
);
    import lcp_pkg::*;

    a_no_out_in_reset: assert property (@(posedge clk) !rst_n |-> !out_valid)
        else $error("byte offered during reset");

    a_ready_in_reset: assert property (@(posedge clk) !rst_n |-> in_ready)
        else $error("input not ready during reset");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(packed_byte) && $stable(run_last))
        else $error("stalled output transaction changed");

    a_second_byte: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_ready && !run_last |=> out_valid)
        else $error("second byte of a coefficient not offered at once");

endmodule

bind lattice_coeff_compress_pack_unit lcp_checker u_lcp_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ready    (coeff.ready),
    .out_valid   (byte_stream.valid),
    .out_ready   (byte_stream.ready),
    .packed_byte (byte_stream.packed_byte),
    .run_last    (byte_stream.run_last)
);
